// ===== src/svas_pkg.sv =====
// shared constants, codes, types and helpers of the stack machine alu step
`default_nettype none
package svas_pkg;

	localparam int WORD_BITS  = 32;
	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int DEPTH_BITS = 9;
	localparam int CNT_BITS   = $clog2(WORD_BITS);

	localparam int S_TDATA_BITS = 80;
	localparam int S_TUSER_BITS = 8;
	localparam int M_TDATA_BITS = 48;
	localparam int M_TUSER_BITS = 8;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDER   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_ILLEGAL = 2'd3;

	localparam int F_CARRY  = 0;
	localparam int F_OVER   = 1;
	localparam int F_BORROW = 2;
	localparam int F_ZERO   = 3;
	localparam int F_SIGN   = 4;
	localparam int F_EVEN   = 5;
	localparam int FLAG_BITS = 6;

	typedef struct packed {
		logic start;
		logic div_mode;
	} svas_ctl_t;

	typedef struct packed {
		logic busy;
		logic last;
	} svas_sts_t;

	function automatic logic [WORD_BITS-1:0] neg_w(input logic [WORD_BITS-1:0] v);
		neg_w = {WORD_BITS{1'b0}} - v;
	endfunction

	function automatic logic [WORD_BITS-1:0] mag_w(input logic [WORD_BITS-1:0] v);
		mag_w = v[WORD_BITS-1] ? neg_w(v) : v;
	endfunction

endpackage
`default_nettype wire

// ===== src/svas_unit.sv =====
// shared iterative unit: shift-add multiply and restoring divide on magnitudes
`default_nettype none
module svas_unit
	import svas_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire svas_ctl_t            ctl,
	input  wire logic [WORD_BITS-1:0] mag_a,
	input  wire logic [WORD_BITS-1:0] mag_b,
	output svas_sts_t                 sts,
	output logic      [WORD_BITS-1:0] hi,
	output logic      [WORD_BITS-1:0] lo
);

	logic                 busy_q;
	logic                 div_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] hi_q;
	logic [WORD_BITS-1:0] lo_q;
	logic [WORD_BITS-1:0] mb_q;

	logic [WORD_BITS:0]   x;
	logic [WORD_BITS+1:0] r;

	// one adder serves both modes
	always_comb begin
		x = div_q ? {hi_q, lo_q[WORD_BITS-1]} : {1'b0, hi_q};
		r = {1'b0, x} + ({2'b00, mb_q} ^ {(WORD_BITS+2){div_q}})
			+ {{(WORD_BITS+1){1'b0}}, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			div_q <= ctl.div_mode;
			hi_q  <= '0;
			lo_q  <= mag_a;
			mb_q  <= mag_b;
		end else if (busy_q) begin
			if (!div_q) begin
				if (lo_q[0]) begin
					hi_q <= r[WORD_BITS:1];
					lo_q <= {r[0], lo_q[WORD_BITS-1:1]};
				end else begin
					hi_q <= x[WORD_BITS:1];
					lo_q <= {x[0], lo_q[WORD_BITS-1:1]};
				end
			end else if (!r[WORD_BITS+1]) begin
				hi_q <= r[WORD_BITS-1:0];
				lo_q <= {lo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				hi_q <= x[WORD_BITS-1:0];
				lo_q <= {lo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.last = busy_q && (cnt_q == CNT_BITS'(WORD_BITS - 1));
	assign hi       = hi_q;
	assign lo       = lo_q;

endmodule
`default_nettype wire

// ===== src/stack_vm_alu_step.sv =====
// top level of the stack machine alu step: sequencer, flags and output register
// add, subtract and error requests pass from accept through NORM1, NORM2 and EXEC to DONE
// a started multiply adds WAIT, FIX and MULOV, a divide or modulo WAIT and FIX; WAIT runs the shared unit
// one request at a time, the next accepted the cycle after a result is registered
// the next is accepted while a result waits to be taken
// asynchronous active-low reset clears all flags and empties the output register
`default_nettype none
module stack_vm_alu_step
	import svas_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_tdata,  // operand_a, operand_b, stack_depth
	input  wire logic [S_TUSER_BITS-1:0] s_tuser,  // opcode
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic      [M_TDATA_BITS-1:0] m_tdata,  // result_value, new_depth
	output logic      [M_TUSER_BITS-1:0] m_tuser   // status, carry, overflow, borrow, zero, sign, even
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NORM1 = 3'd1;
	localparam logic [2:0] S_NORM2 = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_FIX   = 3'd5;
	localparam logic [2:0] S_MULOV = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]            state_q;
	logic [2:0]            op_q;
	logic [WORD_BITS-1:0]  a_q;
	logic [WORD_BITS-1:0]  b_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [WORD_BITS-1:0]  res_q;
	logic [1:0]            stat_q;
	logic [PROD_BITS-1:0]  p_q;
	logic [FLAG_BITS-1:0]  flags_q;
	logic                  m_tvalid_q;

	svas_ctl_t            ctl;
	svas_sts_t            sts;
	logic [WORD_BITS-1:0] u_hi;
	logic [WORD_BITS-1:0] u_lo;

	logic [WORD_BITS:0]    sum33;
	logic [WORD_BITS:0]    dif33;
	logic [PROD_BITS-1:0]  mag64;
	logic [PROD_BITS:0]    t65;
	logic                  ov_pos;
	logic                  ov_neg;
	logic                  b_zero;
	logic [FLAG_BITS-1:0]  flags_nx;
	logic [DEPTH_BITS-1:0] depth_out;

	svas_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.mag_a  (mag_w(a_q)),
		.mag_b  (mag_w(b_q)),
		.sts    (sts),
		.hi     (u_hi),
		.lo     (u_lo)
	);

	always_comb begin
		b_zero  = (b_q == '0);
		sum33   = {a_q[WORD_BITS-1], a_q} + {b_q[WORD_BITS-1], b_q};
		dif33   = {a_q[WORD_BITS-1], a_q} - {b_q[WORD_BITS-1], b_q};
		mag64   = {u_hi, u_lo};
		t65     = {p_q[PROD_BITS-1], p_q}
			- {{(PROD_BITS-WORD_BITS+1){b_q[WORD_BITS-1]}}, b_q};
		ov_pos  = !p_q[PROD_BITS-1] && (|p_q[PROD_BITS-2:WORD_BITS-1]);
		ov_neg  = !(!t65[PROD_BITS] && (|t65[PROD_BITS-1:WORD_BITS-1]));
		ctl.start    = (state_q == S_EXEC) && (depth_q >= DEPTH_BITS'(2))
			&& ((op_q == OP_MUL) || (((op_q == OP_DIV) || (op_q == OP_MOD)) && !b_zero));
		ctl.div_mode = (op_q != OP_MUL);
		flags_nx = flags_q;
		if (stat_q == ST_OK) begin
			flags_nx[F_ZERO] = (res_q == '0);
			flags_nx[F_SIGN] = res_q[WORD_BITS-1];
			flags_nx[F_EVEN] = !res_q[0];
		end
		depth_out = (stat_q == ST_OK) ? depth_q - DEPTH_BITS'(1) : depth_q;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			flags_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_NORM1;
					end
				end
				S_NORM1: state_q <= S_NORM2;
				S_NORM2: state_q <= S_EXEC;
				S_EXEC: begin
					if (ctl.start) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_DONE;
						if (depth_q >= DEPTH_BITS'(2)) begin
							if (op_q == OP_ADD) begin
								flags_q[F_CARRY] <= !b_q[WORD_BITS-1] && !b_zero
									&& !sum33[WORD_BITS] && sum33[WORD_BITS-1];
								flags_q[F_OVER]  <= !b_q[WORD_BITS-1] && !b_zero
									&& !sum33[WORD_BITS] && sum33[WORD_BITS-1];
							end else if (op_q == OP_SUB) begin
								flags_q[F_BORROW] <= dif33[WORD_BITS];
							end
						end
					end
				end
				S_WAIT: begin
					if (sts.last) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: state_q <= (op_q == OP_MUL) ? S_MULOV : S_DONE;
				S_MULOV: begin
					state_q <= S_DONE;
					if (b_zero) begin
						flags_q[F_OVER] <= 1'b0;
					end else if (b_q[WORD_BITS-1]) begin
						flags_q[F_OVER] <= ov_neg;
					end else begin
						flags_q[F_OVER] <= ov_pos;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						flags_q    <= flags_nx;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_q    <= s_tuser[2:0];
					a_q     <= s_tdata[WORD_BITS-1:0];
					b_q     <= s_tdata[2*WORD_BITS-1:WORD_BITS];
					depth_q <= s_tdata[2*WORD_BITS+DEPTH_BITS-1:2*WORD_BITS];
				end
			end
			S_NORM1: begin
				// subtract of a negative becomes an add
				if (op_q == OP_SUB && b_q[WORD_BITS-1]) begin
					op_q <= OP_ADD;
					b_q  <= neg_w(b_q);
				end
			end
			S_NORM2: begin
				// add with a negative operand becomes a subtract
				if (op_q == OP_ADD && (a_q[WORD_BITS-1] || b_q[WORD_BITS-1])) begin
					op_q <= OP_SUB;
					if (a_q[WORD_BITS-1]) begin
						a_q <= b_q;
						b_q <= neg_w(a_q);
					end else begin
						b_q <= neg_w(b_q);
					end
				end
			end
			S_EXEC: begin
				if (depth_q < DEPTH_BITS'(2)) begin
					res_q  <= '0;
					stat_q <= ST_UNDER;
				end else begin
					unique case (op_q)
						OP_ADD: begin
							res_q  <= sum33[WORD_BITS-1:0];
							stat_q <= ST_OK;
						end
						OP_SUB: begin
							res_q  <= dif33[WORD_BITS-1:0];
							stat_q <= ST_OK;
						end
						OP_MUL: begin
							res_q  <= '0;
							stat_q <= ST_OK;
						end
						OP_DIV, OP_MOD: begin
							res_q  <= '0;
							stat_q <= b_zero ? ST_DIVZERO : ST_OK;
						end
						default: begin
							res_q  <= '0;
							stat_q <= ST_ILLEGAL;
						end
					endcase
				end
			end
			S_FIX: begin
				if (op_q == OP_MUL) begin
					p_q <= (a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1])
						? {PROD_BITS{1'b0}} - mag64 : mag64;
				end else if (op_q == OP_DIV) begin
					res_q <= (a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1]) ? neg_w(u_lo) : u_lo;
				end else begin
					res_q <= a_q[WORD_BITS-1] ? neg_w(u_hi) : u_hi;
				end
			end
			S_MULOV: res_q <= p_q[WORD_BITS-1:0];
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata <= {{(M_TDATA_BITS-WORD_BITS-DEPTH_BITS){1'b0}}, depth_out, res_q};
					m_tuser <= {flags_nx, stat_q};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== dv/svas_step_checker.sv =====
// checker of the stack machine alu step: predicts each result and compares it
`default_nettype none
module svas_step_checker
	import svas_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_tdata,  // operand_a, operand_b, stack_depth
	input  wire logic [S_TUSER_BITS-1:0] s_tuser,  // opcode
	input  wire logic                    m_tvalid,
	input  wire logic                    m_tready,
	input  wire logic [M_TDATA_BITS-1:0] m_tdata,  // result_value, new_depth
	input  wire logic [M_TUSER_BITS-1:0] m_tuser,  // status, carry, overflow, borrow, zero, sign, even
	output int                           fail_count,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [WORD_BITS-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

	typedef struct packed {
		word_t                  value;
		logic [DEPTH_BITS-1:0]  depth;
		logic [1:0]             status;
		logic [FLAG_BITS-1:0]   flags;
	} alu_outcome_t;

	alu_outcome_t         results_due[$];
	logic [FLAG_BITS-1:0] flag_state;
	int                   fails;

	function automatic word_t trunc_quot(input word_t x, input word_t y);
		word_t mx, my, q;
		mx = x[WORD_BITS-1] ? -x : x;
		my = y[WORD_BITS-1] ? -y : y;
		q  = mx / my;
		return (x[WORD_BITS-1] ^ y[WORD_BITS-1]) ? -q : q;
	endfunction

	function automatic word_t trunc_rem(input word_t x, input word_t y);
		word_t mx, my, r;
		mx = x[WORD_BITS-1] ? -x : x;
		my = y[WORD_BITS-1] ? -y : y;
		r  = mx % my;
		return x[WORD_BITS-1] ? -r : r;
	endfunction

	function automatic alu_outcome_t alu_step_predict(input logic [2:0] op_in, input word_t a_in,
			input word_t b_in, input logic [DEPTH_BITS-1:0] depth_in,
			input logic [FLAG_BITS-1:0] flags_in);
		logic [2:0]   op;
		word_t        a, b, t, r;
		logic [1:0]   st;
		logic         c;
		alu_outcome_t o;
		op = op_in;
		a  = a_in;
		b  = b_in;
		r  = '0;
		st = ST_OK;
		o.flags = flags_in;
		if (depth_in < 2) begin
			st = ST_UNDER;
		end else begin
			// sign normalization: subtract of negative becomes add, add of negative becomes subtract
			if (op == OP_SUB && b[WORD_BITS-1]) begin
				op = OP_ADD;
				b  = -b;
			end
			if (op == OP_ADD && (a[WORD_BITS-1] || b[WORD_BITS-1])) begin
				op = OP_SUB;
				if (a[WORD_BITS-1]) begin
					t = -a;
					a = b;
					b = t;
				end else begin
					b = -b;
				end
			end
			case (op)
				OP_ADD: begin
					c = !b[WORD_BITS-1] && b != '0 && ($signed(a) > $signed(WORD_MAX - b));
					r = a + b;
					o.flags[F_CARRY] = c;
					o.flags[F_OVER]  = c;
				end
				OP_SUB: begin
					r = a - b;
					o.flags[F_BORROW] = $signed(b) > $signed(a);
				end
				OP_MUL: begin
					r = a * b;
					o.flags[F_OVER] = b != '0 && ($signed(a) > $signed(trunc_quot(WORD_MAX, b)));
				end
				OP_DIV: begin
					if (b == '0) st = ST_DIVZERO;
					else r = trunc_quot(a, b);
				end
				OP_MOD: begin
					if (b == '0) st = ST_DIVZERO;
					else r = trunc_rem(a, b);
				end
				default: st = ST_ILLEGAL;
			endcase
		end
		if (st == ST_OK) begin
			o.flags[F_ZERO] = (r == '0);
			o.flags[F_SIGN] = r[WORD_BITS-1];
			o.flags[F_EVEN] = !r[0];
			o.depth = depth_in - 1'b1;
		end else begin
			o.flags = flags_in;
			r = '0;
			o.depth = depth_in;
		end
		o.value  = r;
		o.status = st;
		return o;
	endfunction

	function automatic int field_mismatch(input string name, input word_t expected, input word_t actual);
		if (expected === actual) return 0;
		$error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alu_outcome_t due, got;
		string        flag_names[FLAG_BITS];
		flag_names = '{"carry_flag", "overflow_flag", "borrow_flag", "zero_flag", "sign_flag",
			"even_flag"};
		if (!arst_n) begin
			flag_state = '0;
			results_due.delete();
			fails = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				due = alu_step_predict(s_tuser[2:0], s_tdata[WORD_BITS-1:0],
					s_tdata[2*WORD_BITS-1:WORD_BITS],
					s_tdata[2*WORD_BITS+DEPTH_BITS-1:2*WORD_BITS], flag_state);
				flag_state = due.flags;
				results_due.push_back(due);
			end
			if (m_tvalid && m_tready) begin
				got.value  = m_tdata[WORD_BITS-1:0];
				got.depth  = m_tdata[WORD_BITS+DEPTH_BITS-1:WORD_BITS];
				got.status = m_tuser[1:0];
				got.flags  = m_tuser[2+FLAG_BITS-1:2];
				if (results_due.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					due = results_due.pop_front();
					fails += field_mismatch("result_value", due.value, got.value);
					fails += field_mismatch("new_depth", word_t'(due.depth), word_t'(got.depth));
					fails += field_mismatch("status", word_t'(due.status), word_t'(got.status));
					for (int i = 0; i < FLAG_BITS; i++)
						fails += field_mismatch(flag_names[i], word_t'(due.flags[i]),
							word_t'(got.flags[i]));
				end
			end
			fail_count  <= fails;
			outstanding <= results_due.size();
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_stack_vm_alu_step.sv =====
// testbench top of the stack machine alu step: clock, reset, requests and verdict
`default_nettype none
module tb_stack_vm_alu_step
	import svas_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [WORD_BITS-1:0] word_t;

	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t MINUS_ONE = '1;

	localparam logic [2:0] OP_UNDEF_5 = 3'd5;
	localparam logic [2:0] OP_UNDEF_6 = 3'd6;
	localparam logic [2:0] OP_UNDEF_7 = 3'd7;

	localparam int RANDOM_PER_PHASE = 560;
	localparam int DRAIN_LIMIT      = 20000;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;   // operand_a, operand_b, stack_depth
	logic [S_TUSER_BITS-1:0] s_tuser;   // opcode
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;   // result_value, new_depth
	logic [M_TUSER_BITS-1:0] m_tuser;   // status, carry, overflow, borrow, zero, sign, even

	int fail_count;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;

	stack_vm_alu_step u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	svas_step_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_request(input logic [2:0] op, input word_t a, input word_t b,
			input logic [DEPTH_BITS-1:0] depth);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 48)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_BITS-2*WORD_BITS-DEPTH_BITS){1'b0}}, depth, b, a};
		s_tuser  <= {{(S_TUSER_BITS-3){1'b0}}, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic word_t pick_operand();
		case ($urandom_range(9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return MINUS_ONE;
			4: return word_t'(1);
			5, 6: return word_t'($urandom_range(0, 64)) - word_t'(32);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_random_request();
		logic [2:0]            op;
		logic [DEPTH_BITS-1:0] depth;
		int                    roll;
		roll = $urandom_range(99);
		op = (roll < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
		roll = $urandom_range(99);
		if (roll < 6) depth = DEPTH_BITS'($urandom_range(0, 1));
		else if (roll < 12) depth = DEPTH_BITS'($urandom_range(257, 511));
		else depth = DEPTH_BITS'($urandom_range(2, 256));
		send_request(op, pick_operand(), pick_operand(), depth);
	endtask

	initial begin
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		arst_n      <= 1'b0;
		tx_idle_pct = 16;
		rx_idle_pct = 77;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shallow stack, underflow ahead of illegal opcode, depth extremes, then signed corner cases of each opcode
		send_request(OP_ADD, word_t'(3), word_t'(4), 9'd0);
		send_request(OP_UNDEF_7, word_t'(3), word_t'(4), 9'd1);
		send_request(OP_ADD, WORD_MAX, word_t'(1), 9'd2);
		send_request(OP_ADD, WORD_MAX, WORD_MAX, 9'd256);
		send_request(OP_ADD, word_t'(-5), word_t'(3), 9'd511);
		send_request(OP_ADD, word_t'(5), word_t'(-3), 9'd300);
		send_request(OP_ADD, WORD_MIN, WORD_MIN, 9'd10);
		send_request(OP_SUB, word_t'(3), word_t'(5), 9'd10);
		send_request(OP_SUB, word_t'(5), word_t'(-3), 9'd10);
		send_request(OP_SUB, WORD_MIN, word_t'(1), 9'd10);
		send_request(OP_SUB, '0, WORD_MIN, 9'd10);
		send_request(OP_MUL, WORD_MAX, word_t'(2), 9'd10);
		send_request(OP_MUL, MINUS_ONE, MINUS_ONE, 9'd10);
		send_request(OP_MUL, WORD_MIN, MINUS_ONE, 9'd10);
		send_request(OP_MUL, '0, WORD_MAX, 9'd10);
		send_request(OP_DIV, WORD_MIN, MINUS_ONE, 9'd10);
		send_request(OP_DIV, word_t'(7), word_t'(-2), 9'd10);
		send_request(OP_DIV, word_t'(-7), word_t'(2), 9'd10);
		send_request(OP_DIV, WORD_MAX, '0, 9'd10);
		send_request(OP_MOD, WORD_MIN, MINUS_ONE, 9'd10);
		send_request(OP_MOD, word_t'(-7), word_t'(2), 9'd10);
		send_request(OP_MOD, word_t'(7), word_t'(-2), 9'd10);
		send_request(OP_MOD, WORD_MIN, '0, 9'd10);
		send_request(OP_UNDEF_5, word_t'(1), word_t'(1), 9'd10);
		send_request(OP_UNDEF_6, word_t'(1), word_t'(1), 9'd10);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 77 : 0;
			rx_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 16 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i == RANDOM_PER_PHASE / 2) drain_results();
				send_random_request();
			end
			drain_results();
		end

		s_tvalid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && outstanding != 0; i++) @(posedge clk);
		repeat (60) @(posedge clk);
		if (outstanding != 0) $error("%0d results never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
src/svas_pkg.sv
src/svas_unit.sv
src/stack_vm_alu_step.sv
dv/svas_step_checker.sv
dv/tb_stack_vm_alu_step.sv
